@@ rtl/beta_moment_matching_estimator_defines.svh @@
// Assertion macros for the beta moment-matching estimator.
`ifndef BETA_MOMENT_MATCHING_ESTIMATOR_DEFINES_SVH
`define BETA_MOMENT_MATCHING_ESTIMATOR_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BMME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define BMME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bmme_pkg.sv @@
// Shared constants and types of the beta moment-matching estimator.
`timescale 1ns / 1ps
package bmme_pkg;
  localparam int DIMENSIONS_DEF = 4;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 88;
  localparam int DIV_W          = 64;
  localparam int MUL_A_W        = 33;
  localparam int MUL_B_W        = 24;
  localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;
endpackage

@@ rtl/bmme_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bmme_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bmme_pkg::div_req_t req,
  output bmme_pkg::div_rsp_t rsp
);
  localparam int CNT_W = $clog2(bmme_pkg::DIV_W);

  logic                        busy_r, done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [bmme_pkg::DIV_W-1:0]  num_r, den_r, rem_r, rem_nxt;
  logic [bmme_pkg::DIV_W:0]    shifted;
  logic                        qbit;

  always_comb begin
    shifted = {rem_r, num_r[bmme_pkg::DIV_W-1]};
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt = bmme_pkg::DIV_W'(shifted - {1'b0, den_r});
      qbit    = 1'b1;
    end else begin
      rem_nxt = shifted[bmme_pkg::DIV_W-1:0];
      qbit    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[bmme_pkg::DIV_W-2:0], qbit};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = num_r;
endmodule

@@ rtl/bmme_mul.sv @@
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
module bmme_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bmme_pkg::MUL_A_W-1:0] a,
  input  logic [bmme_pkg::MUL_B_W-1:0] b,
  output logic [bmme_pkg::MUL_P_W-1:0] prod
);
  logic [bmme_pkg::MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= bmme_pkg::MUL_P_W'(a) * bmme_pkg::MUL_P_W'(b);
    end
  end

  assign prod = prod_r;
endmodule

@@ rtl/beta_moment_matching_estimator.sv @@
// Top level of the beta moment-matching estimator: sequencer, state and ports.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: dim_index, sample; tuser: start_of_vector
//  out_    | out | out_tvalid/out_tready| tdata: out_dim, alpha, beta, mean; tuser: zero_var
//  cfg_    | in  | cfg_wr_en            | cfg_index, cfg_wdata
//
// The time from acceptance to out_tvalid is set by the shared 64-bit divider: delta/n
// and S/n always, then mu(1-mu)/v and up to two blend divisions, plus the multiplier
// steps. Zero variance or a non-positive z skips the later divisions. The next element
// can be accepted in the idle state that follows S_OUT.
// in_tready is high only while the sequencer idles; a finished result sits in the
// output register and the next element is taken while it waits.
// Synchronous active-low reset; no clearing pass. Out-of-range dimensions are
// accepted and dropped without any state change.
`timescale 1ns / 1ps
`include "beta_moment_matching_estimator_defines.svh"
module beta_moment_matching_estimator #(
  parameter int DIMENSIONS = bmme_pkg::DIMENSIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bmme_pkg::IN_DATA_W-1:0]  in_tdata,   // [1:0] dim_index, [33:2] sample
  input  logic                            in_tuser,   // [0] start_of_vector
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bmme_pkg::OUT_DATA_W-1:0] out_tdata,  // [1:0] dim, [33:2] alpha,
                                                      // [65:34] beta, [82:66] mean
  output logic                            out_tuser,  // [0] zero_variance
  input  logic                            cfg_wr_en,
  input  logic [bmme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmme_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int DIM_W = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NRM1 = 4'd1;
  localparam logic [3:0] S_NRM2 = 4'd2;
  localparam logic [3:0] S_NRM3 = 4'd3;
  localparam logic [3:0] S_DLT  = 4'd4;
  localparam logic [3:0] S_DIV1 = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_VAR  = 4'd8;
  localparam logic [3:0] S_Z    = 4'd9;
  localparam logic [3:0] S_BL1  = 4'd10;
  localparam logic [3:0] S_BL2  = 4'd11;
  localparam logic [3:0] S_BL3  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  // configuration
  logic [31:0] lower_r [DIMENSIONS];
  logic [31:0] scale_r [DIMENSIONS];
  // estimator state
  logic [31:0] obs_cnt_r;
  logic [16:0] mean_r [DIMENSIONS];
  logic [63:0] sq_r   [DIMENSIONS];

  logic [3:0]       state_r, state_nxt;
  logic [DIM_W-1:0] dim_r;
  logic [1:0]       odim_r;
  logic [32:0]      n_r, diff_r;
  logic [31:0]      scl_r;
  logic [16:0]      y_r, mu_r, mun_r;
  logic [48:0]      t_r;
  logic [47:0]      z_r, p_r;
  logic [40:0]      lo_r;
  logic             sel_r, zv_r;
  logic [31:0]      alpha_r, beta_r;
  logic             out_tvalid_r;
  logic [bmme_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic             out_tuser_r;

  // input fields
  logic [1:0]       in_dim;
  logic [31:0]      in_smp;
  logic [DIM_W-1:0] in_idx;
  logic             in_ok, acc_in;
  logic [31:0]      cnt_nxt;
  logic [31:0]      lo_sel;

  assign in_dim  = in_tdata[1:0];
  assign in_smp  = in_tdata[33:2];
  assign in_idx  = in_dim[DIM_W-1:0];
  assign in_ok   = ({1'b0, in_dim} < 3'(DIMENSIONS));
  assign in_tready = (state_r == S_IDLE);
  assign acc_in  = in_tvalid && in_tready && in_ok;
  assign cnt_nxt = obs_cnt_r + {31'b0, in_tuser};
  assign lo_sel  = lower_r[in_idx];

  // shared units
  bmme_pkg::div_req_t div_req;
  bmme_pkg::div_rsp_t div_rsp;
  logic                         mul_en;
  logic [bmme_pkg::MUL_A_W-1:0] mul_a;
  logic [bmme_pkg::MUL_B_W-1:0] mul_b;
  logic [bmme_pkg::MUL_P_W-1:0] mul_p;

  bmme_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  bmme_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .prod(mul_p));

  // datapath helpers
  logic [17:0] delta;
  logic [16:0] dmag, q17, mun_c, emag, wgt, bwgt;
  logic [16:0] e_diff;
  logic [49:0] qsum;
  logic [64:0] sq_sum;
  logic [63:0] sq_new;
  logic [65:0] pfull;
  logic [47:0] p_c, r_c;
  logic [31:0] r_sat;
  logic        out_free;

  // y and mu are stable from S_DLT on
  assign delta  = {1'b0, y_r} - {1'b0, mu_r};
  assign dmag   = delta[17] ? 17'(-delta) : delta[16:0];
  assign q17    = div_rsp.quo[16:0];
  assign mun_c  = delta[17] ? mu_r - q17 : mu_r + q17;
  assign e_diff = y_r - mun_r;
  assign emag   = (y_r >= mun_r) ? e_diff : 17'(mun_r - y_r);
  assign qsum   = {1'b0, t_r} + 50'(mul_p[bmme_pkg::MUL_P_W-1:16]);
  assign sq_sum = {1'b0, sq_r[dim_r]} + 65'(mul_p);
  assign sq_new = sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
  assign bwgt   = bmme_pkg::ONE_Q16 - mun_r;
  assign wgt    = sel_r ? bwgt : mun_r;
  assign pfull  = {mul_p[41:0], 24'b0} + 66'(lo_r);
  assign p_c    = pfull[63:16];
  assign r_c    = p_r - div_rsp.quo[47:0];
  assign r_sat  = (|r_c[47:32]) ? bmme_pkg::SAT32 : r_c[31:0];
  assign out_free = !out_tvalid_r || out_tready;

  // sequencer and shared-unit operand selection
  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = 64'(n_r);
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      S_IDLE: if (acc_in) state_nxt = S_NRM1;
      S_NRM1: begin
        if (diff_r[32] || diff_r == '0) begin
          state_nxt = S_DLT;
        end else begin
          mul_en = 1'b1;
          mul_a  = diff_r;
          mul_b  = {8'b0, scl_r[31:16]};
          state_nxt = S_NRM2;
        end
      end
      S_NRM2: begin
        mul_en = 1'b1;
        mul_a  = diff_r;
        mul_b  = {8'b0, scl_r[15:0]};
        state_nxt = S_NRM3;
      end
      S_NRM3: state_nxt = S_DLT;
      S_DLT: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(dmag);
        state_nxt = S_DIV1;
      end
      S_DIV1: if (div_rsp.done) state_nxt = S_PRD;
      S_PRD: begin
        mul_en = 1'b1;
        mul_a  = 33'(dmag);
        mul_b  = 24'(emag);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        div_req.start = 1'b1;
        div_req.num   = sq_new;
        mul_en = 1'b1;
        mul_a  = 33'(mun_r);
        mul_b  = 24'(bwgt);
        state_nxt = S_VAR;
      end
      S_VAR: begin
        if (div_rsp.done) begin
          if (div_rsp.quo == '0) begin
            state_nxt = S_OUT;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = {mul_p[47:0], 16'b0};
            div_req.den   = div_rsp.quo;
            state_nxt = S_Z;
          end
        end
      end
      S_Z: begin
        if (div_rsp.done) begin
          if (div_rsp.quo <= 64'(bmme_pkg::ONE_Q16)) begin
            state_nxt = S_OUT;
          end else begin
            // low half of z = quotient - 1.0
            mul_en = 1'b1;
            mul_a  = 33'(mun_r);
            mul_b  = div_rsp.quo[23:0] - 24'(bmme_pkg::ONE_Q16);
            state_nxt = S_BL1;
          end
        end
      end
      S_BL1: begin
        mul_en = 1'b1;
        mul_a  = 33'(wgt);
        mul_b  = z_r[47:24];
        state_nxt = S_BL2;
      end
      S_BL2: begin
        if (p_c <= 48'(bmme_pkg::ONE_Q16)) begin
          if (sel_r) begin
            state_nxt = S_OUT;
          end else begin
            mul_en = 1'b1;
            mul_a  = 33'(bwgt);
            mul_b  = z_r[23:0];
            state_nxt = S_BL1;
          end
        end else begin
          div_req.start = 1'b1;
          div_req.num   = 64'(p_c - 48'(bmme_pkg::ONE_Q16)) + 64'(n_r) - 64'd1;
          state_nxt = S_BL3;
        end
      end
      S_BL3: begin
        if (div_rsp.done) begin
          if (sel_r) begin
            state_nxt = S_OUT;
          end else begin
            mul_en = 1'b1;
            mul_a  = 33'(bwgt);
            mul_b  = z_r[23:0];
            state_nxt = S_BL1;
          end
        end
      end
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      obs_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < DIMENSIONS; i++) begin
        lower_r[i] <= '0;
        scale_r[i] <= 32'(bmme_pkg::ONE_Q16);
        mean_r[i]  <= bmme_pkg::ONE_Q16;
        sq_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en && (cfg_index < bmme_pkg::CFG_IDX_W'(2 * DIMENSIONS))) begin
        if (cfg_index[0]) scale_r[cfg_index[DIM_W:1]] <= cfg_wdata;
        else              lower_r[cfg_index[DIM_W:1]] <= cfg_wdata;
      end
      if (acc_in) obs_cnt_r <= cnt_nxt;
      if (state_r == S_ACC) begin
        sq_r[dim_r]   <= sq_new;
        mean_r[dim_r] <= mun_r;
      end
      if (state_r == S_OUT && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready)              out_tvalid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc_in) begin
      dim_r  <= in_idx;
      odim_r <= in_dim;
      n_r    <= {1'b0, cnt_nxt} + 33'd1;
      diff_r <= {in_smp[31], in_smp} - {lo_sel[31], lo_sel};
      scl_r  <= scale_r[in_idx];
      mu_r   <= mean_r[in_idx];
      y_r    <= '0;
      sel_r  <= 1'b0;
      zv_r   <= 1'b0;
    end
    unique case (state_r)
      S_NRM2: t_r <= mul_p[48:0];
      S_NRM3: y_r <= (qsum > 50'(bmme_pkg::ONE_Q16)) ? bmme_pkg::ONE_Q16 : qsum[16:0];
      S_DIV1: if (div_rsp.done) mun_r <= mun_c;
      S_VAR: begin
        if (div_rsp.done && div_rsp.quo == '0) begin
          zv_r    <= 1'b1;
          alpha_r <= bmme_pkg::SAT32;
          beta_r  <= bmme_pkg::SAT32;
        end
      end
      S_Z: begin
        if (div_rsp.done) begin
          z_r     <= div_rsp.quo[47:0] - 48'(bmme_pkg::ONE_Q16);
          alpha_r <= 32'(bmme_pkg::ONE_Q16);
          beta_r  <= 32'(bmme_pkg::ONE_Q16);
        end
      end
      S_BL1: lo_r <= mul_p[40:0];
      S_BL2: begin
        p_r <= p_c;
        if (p_c <= 48'(bmme_pkg::ONE_Q16)) sel_r <= 1'b1;
      end
      S_BL3: begin
        if (div_rsp.done) begin
          if (sel_r) beta_r <= r_sat;
          else       alpha_r <= r_sat;
          sel_r <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_tdata_r <= {5'b0, mun_r, beta_r, alpha_r, odim_r};
          out_tuser_r <= zv_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // assertions
  `BMME_ASSERT_NXT(a_accept_leaves_idle, acc_in, state_r == S_NRM1, "accepted element not started")
  `BMME_ASSERT_NXT(a_result_posted, state_r == S_OUT && out_free, out_tvalid_r, "result not posted")
  `BMME_ASSERT_NOW(a_div_no_restart, div_rsp.busy, !div_req.start, "divider restarted while busy")
  `BMME_ASSERT_NOW(a_mean_range, state_r == S_ACC, mun_r <= bmme_pkg::ONE_Q16, "mean above 1.0")
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the beta moment-matching estimator.
`timescale 1ns / 1ps
module tb_top;
  // Register map: lower bound and scale per dimension, anything past 7 is dropped.
  localparam logic [bmme_pkg::CFG_IDX_W-1:0] REG_LOWER_0 = 4'd0;
  localparam logic [bmme_pkg::CFG_IDX_W-1:0] REG_SCALE_0 = 4'd1;
  localparam logic [bmme_pkg::CFG_IDX_W-1:0] REG_LAST    = 4'd7;
  localparam logic [bmme_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 4'd15;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ONE_FX  = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]  dim;
    logic [31:0] smp;
    logic        sov;
  } sample_t;

  typedef struct packed {
    logic [1:0]  dim;
    logic [31:0] alpha;
    logic [31:0] beta;
    logic [16:0] mean;
    logic        zero_var;
  } estimate_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [bmme_pkg::IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [bmme_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en;
  logic [bmme_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bmme_pkg::CFG_DATA_W-1:0] cfg_wdata;

  beta_moment_matching_estimator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the block: configuration and per-dimension statistics.
  logic [31:0] lower_sh [4];
  logic [31:0] scale_fx [4];
  logic [31:0] obs_count;
  logic [16:0] mean_acc [4];
  logic [63:0] sq_dev_acc [4];

  sample_t   sample_q [$];     // transactions waiting to be driven
  estimate_t estimate_q [$];   // predicted results, oldest first
  int        errors = 0;
  int        pushed = 0;
  int        accepted = 0;
  bit        in_taken = 0;
  bit        quiet = 0;        // no idling on either side when set
  int        in_gap = 0;
  int        out_gap = 0;

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // Blend toward 1/n: floor((1 + (n-1)p)/n), clamped to [1.0, saturation].
  function automatic logic [31:0] blend_param(longint unsigned weight, longint unsigned z,
                                              longint unsigned n);
    longint unsigned p, d, r;
    p = (weight * z) >> 16;
    if (p <= 64'd65536) return ONE_FX;
    d = p - 64'd65536;
    r = p - (d + n - 1) / n;
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  // Welford update for one element and the moment-matched parameters.
  function automatic estimate_t update_estimate(sample_t s);
    estimate_t res;
    longint diff, mu, delta, mu_new, e, z;
    longint unsigned d, q, y, n, v, mm, prod;
    if (s.sov) obs_count = obs_count + 32'd1;
    n = {32'd0, obs_count} + 64'd1;
    diff = longint'($signed(s.smp)) - longint'($signed(lower_sh[s.dim]));
    if (diff <= 0) begin
      y = 0;
    end else begin
      d = diff;
      q = d * {48'd0, scale_fx[s.dim][31:16]} + ((d * {48'd0, scale_fx[s.dim][15:0]}) >> 16);
      y = (q > 64'd65536) ? 64'd65536 : q;
    end
    mu = {47'd0, mean_acc[s.dim]};
    delta = longint'(y) - mu;
    mu_new = mu + delta / longint'(n);
    e = longint'(y) - mu_new;
    prod = delta * e;
    if (sq_dev_acc[s.dim] > 64'hFFFF_FFFF_FFFF_FFFF - prod)
      sq_dev_acc[s.dim] = 64'hFFFF_FFFF_FFFF_FFFF;
    else
      sq_dev_acc[s.dim] = sq_dev_acc[s.dim] + prod;
    mean_acc[s.dim] = mu_new[16:0];
    v = sq_dev_acc[s.dim] / n;
    res.dim = s.dim;
    res.mean = mu_new[16:0];
    res.zero_var = (v == 0);
    if (v == 0) begin
      res.alpha = bmme_pkg::SAT32;
      res.beta = bmme_pkg::SAT32;
    end else begin
      mm = longint'(mu_new) * (64'd65536 - longint'(mu_new));
      z = longint'((mm << 16) / v) - 64'sd65536;
      if (z <= 0) begin
        res.alpha = ONE_FX;
        res.beta = ONE_FX;
      end else begin
        res.alpha = blend_param(mu_new, z, n);
        res.beta = blend_param(64'd65536 - mu_new, z, n);
      end
    end
    return res;
  endfunction

  // Monitor: config shadow, input prediction and result checking, all at the rising edge.
  always @(posedge clk) begin
    estimate_t want, got;
    sample_t s;
    if (rst_n) begin
      if (cfg_wr_en && cfg_index <= REG_LAST) begin
        if (cfg_index[0]) scale_fx[cfg_index[2:1]] = cfg_wdata;
        else lower_sh[cfg_index[2:1]] = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        s.dim = in_tdata[1:0];
        s.smp = in_tdata[33:2];
        s.sov = in_tuser;
        estimate_q.insert(estimate_q.size(), update_estimate(s));
        accepted++;
        in_taken = 1;
      end
      if (out_tvalid && out_tready) begin
        got.dim = out_tdata[1:0];
        got.alpha = out_tdata[33:2];
        got.beta = out_tdata[65:34];
        got.mean = out_tdata[82:66];
        got.zero_var = out_tuser;
        if (estimate_q.size() == 0) begin
          report_mismatch("unexpected transaction", 64'd0, 64'(got.dim));
        end else begin
          want = estimate_q.pop_front();
          if (got.dim != want.dim) report_mismatch("dim", 64'(want.dim), 64'(got.dim));
          if (got.alpha != want.alpha)
            report_mismatch("alpha", 64'(want.alpha), 64'(got.alpha));
          if (got.beta != want.beta) report_mismatch("beta", 64'(want.beta), 64'(got.beta));
          if (got.mean != want.mean) report_mismatch("mean", 64'(want.mean), 64'(got.mean));
          if (got.zero_var != want.zero_var)
            report_mismatch("zero_variance", 64'(want.zero_var), 64'(got.zero_var));
        end
      end
    end
  end

  // Input driver: holds a transaction until taken, idles in random bursts.
  always @(negedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold until accepted
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      in_gap = $urandom_range(0, 13);
      in_tvalid <= 1'b0;
    end else if (sample_q.size() > 0) begin
      s = sample_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= {6'd0, s.smp, s.dim};
      in_tuser <= s.sov;
    end else begin
      in_tvalid <= 1'b0;
    end
    in_taken = 0;
  end

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic add_sample(logic [1:0] dim, logic [31:0] smp, logic sov);
    sample_t s;
    s.dim = dim;
    s.smp = smp;
    s.sov = sov;
    sample_q.insert(sample_q.size(), s);
    pushed++;
  endtask

  // Block must be idle: every transaction accepted and every result back.
  task automatic drain();
    while (accepted != pushed || estimate_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [bmme_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_lower();
    case ($urandom_range(0, 5))
      0: return NEG_MAX;
      1: return POS_MAX;
      2: return $urandom();
      default: return -$urandom_range(0, 4 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(16384, 2 * 65536);
    endcase
  endfunction

  // Sample near the configured window so normalized values spread over [0,1].
  function automatic logic [31:0] pick_sample(logic [1:0] dim);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return lower_sh[dim] + $urandom_range(0, 6 * 65536) - 32'd65536;
  endfunction

  initial begin
    int ph, k, j;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    obs_count = 0;
    for (k = 0; k < 4; k++) begin
      lower_sh[k] = 32'd0;
      scale_fx[k] = ONE_FX;
      mean_acc[k] = bmme_pkg::ONE_Q16;
      sq_dev_acc[k] = 64'd0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: element before any start flag, repeats (zero variance), extremes.
    add_sample(2'd0, ONE_FX, 1'b0);
    add_sample(2'd0, ONE_FX, 1'b1);
    add_sample(2'd1, NEG_MAX, 1'b0);
    add_sample(2'd2, POS_MAX, 1'b0);
    add_sample(2'd3, 32'd0, 1'b0);
    add_sample(2'd0, 32'd0, 1'b1);
    add_sample(2'd1, 32'h0000_8000, 1'b0);
    add_sample(2'd2, 32'hFFFF_FFFF, 1'b0);
    add_sample(2'd3, 32'h0000_0001, 1'b0);
    add_sample(2'd0, 32'h0000_4000, 1'b1);
    add_sample(2'd0, 32'h0000_C000, 1'b0);
    add_sample(2'd1, 32'h0000_8000, 1'b1);
    add_sample(2'd1, 32'h0000_8001, 1'b1);
    add_sample(2'd2, 32'h0000_FFFF, 1'b1);
    add_sample(2'd3, 32'h0000_0001, 1'b1);
    drain();

    // Extreme configuration, plus a write to an unmapped index.
    write_reg(REG_LOWER_0, NEG_MAX);
    write_reg(REG_SCALE_0, 32'hFFFF_FFFF);
    write_reg(REG_LOWER_0 + 4'd2, POS_MAX);
    write_reg(REG_SCALE_0 + 4'd2, 32'd0);
    write_reg(REG_LOWER_0 + 4'd4, NEG_MAX);
    write_reg(REG_SCALE_0 + 4'd4, 32'd1);
    write_reg(REG_LOWER_0 + 4'd6, 32'hFFFF_0000);
    write_reg(REG_SCALE_0 + 4'd6, 32'h0000_8000);
    write_reg(REG_UNUSED, 32'h1234_5678);
    for (k = 0; k < 8; k++) add_sample(k[1:0], (k[2]) ? POS_MAX : NEG_MAX, k[0]);
    drain();

    // Random phases, each with a fresh configuration; the last one runs without idling.
    for (ph = 0; ph < 5; ph++) begin
      for (k = 0; k < 4; k++) begin
        write_reg(REG_LOWER_0 + bmme_pkg::CFG_IDX_W'(2 * k), pick_lower());
        write_reg(REG_SCALE_0 + bmme_pkg::CFG_IDX_W'(2 * k), pick_scale());
      end
      if ($urandom_range(0, 1))
        write_reg(bmme_pkg::CFG_IDX_W'(8 + $urandom_range(0, 7)), $urandom());
      if (ph == 4) quiet = 1;
      // Mostly whole vectors in dimension order with random content, some noise.
      for (j = 0; j < 34; j++) begin
        if ($urandom_range(0, 4) == 0) begin
          add_sample(2'($urandom_range(0, 3)), pick_sample(2'($urandom_range(0, 3))),
                     1'($urandom_range(0, 1)));
        end else begin
          for (k = 0; k < 4; k++) add_sample(k[1:0], pick_sample(k[1:0]), k == 0);
        end
      end
      drain();
    end

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
